FILE: rtl/cva_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cva_pkg: shared types and constants for the 2-D valid convolution MAC
// Field widths, request and register codes, and the sequencer microcode.
// ----------------------------------------------------------------------------
package cva_pkg;

  // Field widths of the request and result channels.
  localparam int TYPE_W  = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 16;
  localparam int SUM_W   = 40;
  localparam int PROD_W  = 2 * VALUE_W;
  // Accumulator holds the addend plus many Q7.24 products without wrapping.
  localparam int ACC_W   = SUM_W + 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int KDIM_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_ROWS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_COLS    = 2'd3;

  // Request types.
  localparam logic [TYPE_W-1:0] REQ_KERNEL  = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_SOURCE  = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_COMPUTE = 2'd2;

  // Sequencer step addresses.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_ISSUE  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_DRAIN0 = 3'd2;
  localparam logic [STEP_W-1:0] STEP_DRAIN1 = 3'd3;
  localparam logic [STEP_W-1:0] STEP_RESULT = 3'd4;

  // Jump conditions: when the condition holds, the step counter loads the
  // target; otherwise it advances by one.
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_NEVER    = 2'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS   = 2'd1;
  localparam logic [COND_W-1:0] COND_NO_START = 2'd2;
  localparam logic [COND_W-1:0] COND_MORE     = 2'd3;

  // One control word per step.
  typedef struct packed {
    logic              ready;   // accept a request in this step
    logic              issue;   // issue one kernel tap to the MAC
    logic              emit;    // load the result register
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  // Microcode read-only table.
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t cw;
    cw = '0;
    unique case (step)
      STEP_IDLE: begin
        cw.ready  = 1'b1;
        cw.cond   = COND_NO_START;
        cw.target = STEP_IDLE;
      end
      STEP_ISSUE: begin
        cw.issue  = 1'b1;
        cw.cond   = COND_MORE;
        cw.target = STEP_ISSUE;
      end
      STEP_DRAIN0: begin
        cw.cond   = COND_NEVER;
        cw.target = STEP_IDLE;
      end
      STEP_DRAIN1: begin
        cw.cond   = COND_NEVER;
        cw.target = STEP_IDLE;
      end
      STEP_RESULT: begin
        cw.emit   = 1'b1;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

FILE: rtl/cva_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cva_if: request and result channels of the convolution MAC
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface cva_req_if;
  logic                                valid;
  logic                                ready;
  logic [cva_pkg::TYPE_W-1:0]          req_type;
  logic [cva_pkg::POS_W-1:0]           row;
  logic [cva_pkg::POS_W-1:0]           col;
  logic signed [cva_pkg::VALUE_W-1:0]  value;
  logic signed [cva_pkg::SUM_W-1:0]    addend;

  modport source (output valid, req_type, row, col, value, addend, input ready);
  modport sink   (input valid, req_type, row, col, value, addend, output ready);
endinterface

interface cva_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [cva_pkg::SUM_W-1:0]  sum_out;

  modport source (output valid, sum_out, input ready);
  modport sink   (input valid, sum_out, output ready);
endinterface

FILE: rtl/conv2d_valid_accumulate.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_valid_accumulate: 2-D valid convolution point with accumulation
// Kernel and source writes fill two memories; a compute request walks the
// kernel window through one shared multiply-accumulate under microcode.
// ----------------------------------------------------------------------------
// Kernel and source write requests are taken in the idle step, which they
// do not leave. A compute request whose position lies inside the output
// plane is accepted in the idle step, then walks the kernel taps one by one
// through the single shared multiplier in the issue step, passes the drain
// steps while the memory read and the product register drain into the
// accumulator, and loads the result register in the result step. The result
// waits in its own register, so the next request is taken while it is still
// unread; the result step holds only if the previous result has not been
// taken yet. Compute requests outside the output plane and unknown request
// types are dropped. Sums are Q15.24 and saturate to 40 bits.
module conv2d_valid_accumulate #(
  parameter int MAX_KERNEL      = 5,
  parameter int MAX_SOURCE_SIDE = 36
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [cva_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cva_pkg::CFG_DATA_W-1:0]   cfg_data,
  cva_req_if.sink                          req,
  cva_rsp_if.source                        rsp
);

  localparam int K_DEPTH = MAX_KERNEL * MAX_KERNEL;
  localparam int S_DEPTH = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
  localparam int KA_W    = (K_DEPTH > 1) ? $clog2(K_DEPTH) : 1;
  localparam int SA_W    = $clog2(S_DEPTH);

  // Configuration registers.
  logic [cva_pkg::KDIM_W-1:0] kernel_rows;
  logic [cva_pkg::KDIM_W-1:0] kernel_cols;
  logic [cva_pkg::POS_W-1:0]  out_rows;
  logic [cva_pkg::POS_W-1:0]  out_cols;

  // Sequencer.
  logic [cva_pkg::STEP_W-1:0] step;
  logic [cva_pkg::STEP_W-1:0] step_next;
  cva_pkg::ctrl_word_t        cw;

  logic accept;
  logic start;
  logic hold;
  logic more;
  logic taps_on;
  logic issue_en;

  // Datapath.
  logic [cva_pkg::KDIM_W-1:0]         kr_eff;
  logic [cva_pkg::KDIM_W-1:0]         kc_eff;
  logic [cva_pkg::KDIM_W-1:0]         ti;
  logic [cva_pkg::KDIM_W-1:0]         tj;
  logic [cva_pkg::POS_W-1:0]          row_q;
  logic [cva_pkg::POS_W-1:0]          col_q;
  logic [cva_pkg::POS_W:0]            src_row;
  logic [cva_pkg::POS_W:0]            src_col;
  logic [13:0]                        s_rd_full;
  logic [13:0]                        s_wr_full;
  logic [7:0]                         k_rd_full;
  logic [7:0]                         k_wr_full;
  logic [SA_W-1:0]                    s_rd_addr;
  logic [SA_W-1:0]                    s_wr_addr;
  logic [KA_W-1:0]                    k_rd_addr;
  logic [KA_W-1:0]                    k_wr_addr;
  logic signed [cva_pkg::VALUE_W-1:0] kmem [K_DEPTH];
  logic signed [cva_pkg::VALUE_W-1:0] smem [S_DEPTH];
  logic signed [cva_pkg::VALUE_W-1:0] k_rd;
  logic signed [cva_pkg::VALUE_W-1:0] s_rd;
  logic                               tap_vld;
  logic                               rd_vld;
  logic                               prod_vld;
  logic signed [cva_pkg::PROD_W-1:0]  prod;
  logic signed [cva_pkg::ACC_W-1:0]   acc;
  logic signed [cva_pkg::SUM_W-1:0]   sat_sum;
  logic                               out_vld;
  logic signed [cva_pkg::SUM_W-1:0]   out_sum;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_rows <= 3'd5;
      kernel_cols <= 3'd5;
      out_rows    <= 6'd28;
      out_cols    <= 6'd28;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cva_pkg::CFG_KERNEL_ROWS: kernel_rows <= cfg_data[cva_pkg::KDIM_W-1:0];
        cva_pkg::CFG_KERNEL_COLS: kernel_cols <= cfg_data[cva_pkg::KDIM_W-1:0];
        cva_pkg::CFG_OUT_ROWS:    out_rows    <= cfg_data;
        cva_pkg::CFG_OUT_COLS:    out_cols    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Kernel size limited to the kernel store.
  assign kr_eff  = (int'(kernel_rows) > MAX_KERNEL) ? cva_pkg::KDIM_W'(MAX_KERNEL)
                                                    : kernel_rows;
  assign kc_eff  = (int'(kernel_cols) > MAX_KERNEL) ? cva_pkg::KDIM_W'(MAX_KERNEL)
                                                    : kernel_cols;
  assign taps_on = (kr_eff != '0) && (kc_eff != '0);
  assign more    = taps_on && !((ti == kr_eff - 3'd1) && (tj == kc_eff - 3'd1));

  // Request handshake and start of a compute pass.
  assign cw        = cva_pkg::ucode(step);
  assign req.ready = cw.ready;
  assign accept    = req.valid && req.ready;
  assign start     = accept && (req.req_type == cva_pkg::REQ_COMPUTE)
                     && (req.row < out_rows) && (req.col < out_cols);
  assign hold      = cw.emit && out_vld && !rsp.ready;
  assign issue_en  = cw.issue && taps_on;

  // Next step: jump on the control word's condition, hold while the result
  // register is still full.
  always_comb begin
    priority if (hold) begin
      step_next = step;
    end else begin
      unique case (cw.cond)
        cva_pkg::COND_NEVER:    step_next = step + 3'd1;
        cva_pkg::COND_ALWAYS:   step_next = cw.target;
        cva_pkg::COND_NO_START: step_next = start ? step + 3'd1 : cw.target;
        cva_pkg::COND_MORE:     step_next = more ? cw.target : step + 3'd1;
        default:                step_next = cw.target;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cva_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Tap counters walk the window row by row.
  always_ff @(posedge clk) begin
    if (start) begin
      ti    <= '0;
      tj    <= '0;
      row_q <= req.row;
      col_q <= req.col;
    end else if (issue_en) begin
      if (tj == kc_eff - 3'd1) begin
        tj <= '0;
        ti <= ti + 3'd1;
      end else begin
        tj <= tj + 3'd1;
      end
    end
  end

  // Read addresses for the current tap; a tap past the source store is void.
  assign src_row   = {1'b0, row_q} + {4'b0, ti};
  assign src_col   = {1'b0, col_q} + {4'b0, tj};
  assign tap_vld   = issue_en && (int'(src_row) < MAX_SOURCE_SIDE)
                     && (int'(src_col) < MAX_SOURCE_SIDE);
  assign s_rd_full = 14'(src_row) * 14'(MAX_SOURCE_SIDE) + 14'(src_col);
  assign k_rd_full = 8'(ti) * 8'(MAX_KERNEL) + 8'(tj);
  assign s_rd_addr = s_rd_full[SA_W-1:0];
  assign k_rd_addr = k_rd_full[KA_W-1:0];

  // Write addresses from the request.
  assign s_wr_full = 14'(req.row) * 14'(MAX_SOURCE_SIDE) + 14'(req.col);
  assign k_wr_full = 8'(req.row) * 8'(MAX_KERNEL) + 8'(req.col);
  assign s_wr_addr = s_wr_full[SA_W-1:0];
  assign k_wr_addr = k_wr_full[KA_W-1:0];

  // Kernel memory.
  always_ff @(posedge clk) begin
    if (accept && (req.req_type == cva_pkg::REQ_KERNEL)
        && (int'(req.row) < MAX_KERNEL) && (int'(req.col) < MAX_KERNEL)) begin
      kmem[k_wr_addr] <= req.value;
    end
    k_rd <= kmem[k_rd_addr];
  end

  // Source memory.
  always_ff @(posedge clk) begin
    if (accept && (req.req_type == cva_pkg::REQ_SOURCE)
        && (int'(req.row) < MAX_SOURCE_SIDE) && (int'(req.col) < MAX_SOURCE_SIDE)) begin
      smem[s_wr_addr] <= req.value;
    end
    s_rd <= smem[s_rd_addr];
  end

  // Tap valid follows the read and the product through the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      prod_vld <= 1'b0;
    end else begin
      rd_vld   <= tap_vld;
      prod_vld <= rd_vld;
    end
  end

  // Shared multiplier.
  always_ff @(posedge clk) begin
    prod <= k_rd * s_rd;
  end

  // Accumulator starts from the incoming partial sum.
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= {{(cva_pkg::ACC_W - cva_pkg::SUM_W){req.addend[cva_pkg::SUM_W-1]}},
              req.addend};
    end else if (prod_vld) begin
      acc <= acc + {{(cva_pkg::ACC_W - cva_pkg::PROD_W){prod[cva_pkg::PROD_W-1]}},
                    prod};
    end
  end

  // Saturate to 40 bits when the top accumulator bits disagree.
  always_comb begin
    priority if (acc[cva_pkg::ACC_W-1:cva_pkg::SUM_W-1] == '0
                 || acc[cva_pkg::ACC_W-1:cva_pkg::SUM_W-1] == '1) begin
      sat_sum = acc[cva_pkg::SUM_W-1:0];
    end else if (acc[cva_pkg::ACC_W-1]) begin
      sat_sum = {1'b1, {(cva_pkg::SUM_W-1){1'b0}}};
    end else begin
      sat_sum = {1'b0, {(cva_pkg::SUM_W-1){1'b1}}};
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cw.emit && !hold) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && !hold) begin
      out_sum <= sat_sum;
    end
  end

  assign rsp.valid   = out_vld;
  assign rsp.sum_out = out_sum;

endmodule

FILE: rtl/cva_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cva_checker: port-level checks for the convolution MAC
// Watches the request and result channels over time; bound to the top level.
// ----------------------------------------------------------------------------
module cva_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              req_valid,
  input logic                              req_ready,
  input logic [cva_pkg::TYPE_W-1:0]        req_type,
  input logic                              rsp_valid,
  input logic                              rsp_ready,
  input logic signed [cva_pkg::SUM_W-1:0]  rsp_sum_out
);

  // A result that is not taken stays and keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sum_out))
    else $error("result dropped or changed while stalled");

  // A write transfer never makes the block busy.
  a_write_no_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready
    && (req_type == cva_pkg::REQ_KERNEL || req_type == cva_pkg::REQ_SOURCE)
    |=> req_ready)
    else $error("block busy after a write transfer");

  // A new result is produced only while the block is busy with a compute item.
  a_result_when_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!req_ready))
    else $error("result appeared while the block was idle");

  // No result can follow a request transfer in the very next cycle.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !$rose(rsp_valid))
    else $error("result appeared one cycle after a request transfer");

endmodule

bind conv2d_valid_accumulate cva_checker u_cva_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_type    (req.req_type),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_sum_out (rsp.sum_out)
);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 2-D valid convolution MAC
// Fills the kernel store and the part of the source store that the windows
// reach, walks a short table of directed requests, then runs random phases
// under several kernel and plane sizes. An in-bench model of the stores and
// the window sum predicts every result not typed in by hand, and each result
// transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int KERNEL_SIDE   = 5;
  localparam int SOURCE_SIDE   = 36;
  // Random planes keep their windows inside the top-left square of this side.
  localparam int FILL_SIDE     = 20;
  // First row and column of the far windows that the directed table reads.
  localparam int FAR_EDGE      = 27;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_ITEMS   = 58;
  localparam int NUM_PHASES    = 7;
  localparam int NUM_DIRECTED  = 23;

  // Request code that the block does not know.
  localparam logic [cva_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  localparam logic signed [cva_pkg::SUM_W-1:0]   SUM_MAX = 40'sh7F_FFFF_FFFF;
  localparam logic signed [cva_pkg::SUM_W-1:0]   SUM_MIN = 40'sh80_0000_0000;
  localparam logic signed [cva_pkg::VALUE_W-1:0] Q_MAX   = 16'sh7FFF;
  localparam logic signed [cva_pkg::VALUE_W-1:0] Q_MIN   = 16'sh8000;

  // One request, with an optional result typed in by hand.
  typedef struct packed {
    logic [cva_pkg::TYPE_W-1:0]         kind;
    logic [cva_pkg::POS_W-1:0]          row;
    logic [cva_pkg::POS_W-1:0]          col;
    logic signed [cva_pkg::VALUE_W-1:0] value;
    logic signed [cva_pkg::SUM_W-1:0]   addend;
    logic                               typed;
    logic signed [cva_pkg::SUM_W-1:0]   want;
  } stim_row_t;

  // Directed requests; the stores hold zeros and the reset sizes apply.
  localparam stim_row_t DIRECTED [NUM_DIRECTED] = '{
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    40'sd0,  1'b1, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd27, 6'd27, 16'sd0,    SUM_MAX, 1'b1, SUM_MAX},
    '{cva_pkg::REQ_COMPUTE, 6'd27, 6'd0,  16'sd0,    SUM_MIN, 1'b1, SUM_MIN},
    '{cva_pkg::REQ_COMPUTE, 6'd28, 6'd0,  16'sd0,    40'sd5,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd28, 16'sd0,    40'sd5,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd35, 6'd35, 16'sd0,    SUM_MAX, 1'b0, 40'sd0},
    '{REQ_UNKNOWN,          6'd0,  6'd0,  Q_MAX,     SUM_MAX, 1'b0, 40'sd0},
    '{cva_pkg::REQ_KERNEL,  6'd5,  6'd0,  Q_MAX,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_KERNEL,  6'd0,  6'd35, Q_MIN,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    40'sd0,  1'b1, 40'sd0},
    '{cva_pkg::REQ_KERNEL,  6'd0,  6'd0,  Q_MIN,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_SOURCE,  6'd0,  6'd0,  Q_MIN,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    40'sd0,  1'b1, 40'sd1073741824},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    SUM_MAX, 1'b1, SUM_MAX},
    '{cva_pkg::REQ_SOURCE,  6'd0,  6'd0,  Q_MAX,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    SUM_MIN, 1'b1, SUM_MIN},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    40'sd0,  1'b1, -40'sd1073709056},
    '{cva_pkg::REQ_KERNEL,  6'd4,  6'd4,  Q_MAX,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_SOURCE,  6'd35, 6'd35, Q_MAX,     40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_SOURCE,  6'd4,  6'd4,  16'sh5A5A, 40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd0,  6'd0,  16'sd0,    -40'sd1, 1'b0, 40'sd0},
    '{cva_pkg::REQ_KERNEL,  6'd2,  6'd3,  16'sh2A5A, 40'sd0,  1'b0, 40'sd0},
    '{cva_pkg::REQ_COMPUTE, 6'd27, 6'd27, 16'sd0,    40'sd1,  1'b0, 40'sd0}
  };

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [cva_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cva_pkg::CFG_DATA_W-1:0] cfg_data;

  cva_req_if req_ch ();
  cva_rsp_if rsp_ch ();

  conv2d_valid_accumulate dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Model state: both stores and the size registers.
  logic signed [cva_pkg::VALUE_W-1:0] kernel_w [KERNEL_SIDE][KERNEL_SIDE];
  logic signed [cva_pkg::VALUE_W-1:0] source_s [SOURCE_SIDE][SOURCE_SIDE];
  logic [cva_pkg::KDIM_W-1:0]         kernel_rows = 3'd5;
  logic [cva_pkg::KDIM_W-1:0]         kernel_cols = 3'd5;
  logic [cva_pkg::POS_W-1:0]          out_rows    = 6'd28;
  logic [cva_pkg::POS_W-1:0]          out_cols    = 6'd28;

  logic signed [cva_pkg::SUM_W-1:0] pending_sums [$];
  int fail_count = 0;
  bit quiet      = 1'b1;

  // Free-running clock, 2 ns period.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Wait cycles before the next transfer on either side.
  function automatic int pick_gap();
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  // Source entries that some window reads: the square of the random planes
  // and the two far windows of the reset plane that the directed table uses.
  function automatic bit needs_fill(input int r, input int c);
    bit far_row;
    far_row = (r >= FAR_EDGE) && (r < FAR_EDGE + KERNEL_SIDE);
    return ((r < FILL_SIDE) && (c < FILL_SIDE))
           || (far_row && ((c < KERNEL_SIDE)
                           || ((c >= FAR_EDGE) && (c < FAR_EDGE + KERNEL_SIDE))));
  endfunction

  // Addend plus the kernel window dot product, saturated to 40 bits.
  function automatic logic signed [cva_pkg::SUM_W-1:0] window_sum(
    input logic [cva_pkg::POS_W-1:0] r,
    input logic [cva_pkg::POS_W-1:0] c,
    input logic signed [cva_pkg::SUM_W-1:0] addend
  );
    longint acc;
    int     kr;
    int     kc;
    int     sr;
    int     sc;
    kr  = (kernel_rows > KERNEL_SIDE) ? KERNEL_SIDE : int'(kernel_rows);
    kc  = (kernel_cols > KERNEL_SIDE) ? KERNEL_SIDE : int'(kernel_cols);
    acc = longint'(addend);
    for (int i = 0; i < kr; i++) begin
      for (int j = 0; j < kc; j++) begin
        sr = int'(r) + i;
        sc = int'(c) + j;
        if (sr < SOURCE_SIDE && sc < SOURCE_SIDE) begin
          acc += longint'(kernel_w[i][j]) * longint'(source_s[sr][sc]);
        end
      end
    end
    if (acc > longint'(SUM_MAX)) acc = longint'(SUM_MAX);
    if (acc < longint'(SUM_MIN)) acc = longint'(SUM_MIN);
    return acc[cva_pkg::SUM_W-1:0];
  endfunction

  // Update the model for one accepted request and queue any result.
  task automatic apply_request(input stim_row_t it);
    case (it.kind)
      cva_pkg::REQ_KERNEL: begin
        if (it.row < KERNEL_SIDE && it.col < KERNEL_SIDE) kernel_w[it.row][it.col] = it.value;
      end
      cva_pkg::REQ_SOURCE: begin
        if (it.row < SOURCE_SIDE && it.col < SOURCE_SIDE) source_s[it.row][it.col] = it.value;
      end
      cva_pkg::REQ_COMPUTE: begin
        if (it.row < out_rows && it.col < out_cols) begin
          pending_sums.push_back(it.typed ? it.want : window_sum(it.row, it.col, it.addend));
        end
      end
      default: begin
      end
    endcase
  endtask

  // Drive one request after a random gap and hold it until the transfer.
  task automatic send_request(input stim_row_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= it.kind;
    req_ch.row      <= it.row;
    req_ch.col      <= it.col;
    req_ch.value    <= it.value;
    req_ch.addend   <= it.addend;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(it);
  endtask

  // Stop sending and let the block finish all outstanding work.
  task automatic wait_results_done();
    req_ch.valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all four size registers while the block is idle.
  task automatic write_sizes(input int kr, input int kc, input int orows, input int ocols);
    logic [cva_pkg::CFG_IDX_W-1:0] idx [4];
    int                            val [4];
    idx = '{cva_pkg::CFG_KERNEL_ROWS, cva_pkg::CFG_KERNEL_COLS,
            cva_pkg::CFG_OUT_ROWS, cva_pkg::CFG_OUT_COLS};
    val = '{kr, kc, orows, ocols};
    wait_results_done();
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= cva_pkg::CFG_DATA_W'(val[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
    kernel_rows = cva_pkg::KDIM_W'(kr);
    kernel_cols = cva_pkg::KDIM_W'(kc);
    out_rows    = cva_pkg::POS_W'(orows);
    out_cols    = cva_pkg::POS_W'(ocols);
  endtask

  // Random request: mostly computes inside the plane and writes into the stores.
  function automatic stim_row_t random_request();
    stim_row_t   it;
    int          pick;
    logic [63:0] wide;
    it       = '0;
    pick     = $urandom_range(0, 99);
    wide     = {$urandom(), $urandom()};
    it.value = cva_pkg::VALUE_W'(wide[15:0]);
    case ($urandom_range(0, 7))
      0: it.value = Q_MIN;
      1: it.value = Q_MAX;
      2: it.value = 16'sd0;
      default: begin
      end
    endcase
    wide      = {$urandom(), $urandom()};
    it.addend = wide[cva_pkg::SUM_W-1:0];
    case ($urandom_range(0, 7))
      0: it.addend = SUM_MAX - cva_pkg::SUM_W'($urandom());
      1: it.addend = SUM_MIN + cva_pkg::SUM_W'($urandom());
      2: it.addend = cva_pkg::SUM_W'(longint'($urandom_range(0, 2000000)) - 1000000);
      default: begin
      end
    endcase
    if (pick < 50) begin
      it.kind = cva_pkg::REQ_COMPUTE;
      if ($urandom_range(0, 9) != 0) begin
        it.row = cva_pkg::POS_W'($urandom_range(0, int'(out_rows) - 1));
        it.col = cva_pkg::POS_W'($urandom_range(0, int'(out_cols) - 1));
      end else begin
        it.row = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
        it.col = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
      end
    end else if (pick < 78) begin
      it.kind = cva_pkg::REQ_SOURCE;
      it.row  = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
      it.col  = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
    end else if (pick < 97) begin
      it.kind = cva_pkg::REQ_KERNEL;
      if ($urandom_range(0, 5) != 0) begin
        it.row = cva_pkg::POS_W'($urandom_range(0, KERNEL_SIDE - 1));
        it.col = cva_pkg::POS_W'($urandom_range(0, KERNEL_SIDE - 1));
      end else begin
        it.row = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
        it.col = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
      end
    end else begin
      it.kind = REQ_UNKNOWN;
      it.row  = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
      it.col  = cva_pkg::POS_W'($urandom_range(0, SOURCE_SIDE - 1));
    end
    return it;
  endfunction

  // Compare one result transfer with the oldest predicted sum.
  task automatic check_sum(input logic signed [cva_pkg::SUM_W-1:0] got);
    logic signed [cva_pkg::SUM_W-1:0] want;
    if (pending_sums.size() == 0) begin
      $error("unexpected result transfer: sum_out actual %0d", got);
      fail_count++;
    end else begin
      want = pending_sums.pop_front();
      if (got !== want) begin
        $error("sum_out mismatch: expected %0d, actual %0d", want, got);
        fail_count++;
      end
    end
  endtask

  // Result side: random stalls on ready, check on every transfer.
  initial begin
    int stall;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      check_sum(rsp_ch.sum_out);
    end
  end

  // Request side: reset, store fill, directed table, random phases.
  initial begin
    stim_row_t it;
    int        done;
    int        kr_pick;
    int        kc_pick;
    int        sizes [NUM_PHASES][4];
    // Every fixed plane keeps out + kernel - 1 within the filled square; the
    // sizes cover an empty kernel and kernel sizes above the store.
    sizes = '{'{5, 5, 16, 16}, '{1, 1, 1, 1}, '{1, 5, 20, 1}, '{5, 1, 1, 20},
              '{0, 3, 16, 16}, '{7, 6, 16, 16}, '{2, 2, 19, 19}};
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= '0;
    cfg_data        <= '0;
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= '0;
    req_ch.row      <= '0;
    req_ch.col      <= '0;
    req_ch.value    <= '0;
    req_ch.addend   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Write every store entry that a window reads once, so none is empty.
    it = '0;
    it.kind = cva_pkg::REQ_KERNEL;
    for (int r = 0; r < KERNEL_SIDE; r++) begin
      for (int c = 0; c < KERNEL_SIDE; c++) begin
        it.row = cva_pkg::POS_W'(r);
        it.col = cva_pkg::POS_W'(c);
        send_request(it);
      end
    end
    it.kind = cva_pkg::REQ_SOURCE;
    for (int r = 0; r < SOURCE_SIDE; r++) begin
      for (int c = 0; c < SOURCE_SIDE; c++) begin
        if (needs_fill(r, c)) begin
          it.row = cva_pkg::POS_W'(r);
          it.col = cva_pkg::POS_W'(c);
          send_request(it);
        end
      end
    end

    // Directed table under the reset sizes.
    quiet = 1'b0;
    for (int k = 0; k < NUM_DIRECTED; k++) send_request(DIRECTED[k]);

    // Random phases, each under its own sizes.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1) begin
        kr_pick = $urandom_range(1, KERNEL_SIDE);
        kc_pick = $urandom_range(1, KERNEL_SIDE);
        write_sizes(kr_pick, kc_pick, $urandom_range(1, FILL_SIDE + 1 - kr_pick),
                    $urandom_range(1, FILL_SIDE + 1 - kc_pick));
      end else begin
        write_sizes(sizes[ph][0], sizes[ph][1], sizes[ph][2], sizes[ph][3]);
      end
      quiet = (ph == 2) || ($urandom_range(0, 4) == 0);
      done  = 0;
      while (done < PHASE_ITEMS) begin
        // In phase 3, hold off at mid-phase until every queued result has come back.
        if (ph == 3 && done == PHASE_ITEMS / 2) wait_results_done();
        it = random_request();
        send_request(it);
        if (it.kind != REQ_UNKNOWN) done++;
      end
    end

    wait_results_done();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

FILE: conv2d_valid_accumulate.f
rtl/cva_pkg.sv
rtl/cva_if.sv
rtl/conv2d_valid_accumulate.sv
rtl/cva_checker.sv
bench/testbench.sv
